// ===== rtl/srag_pkg.sv =====
// Shared types and constants for the sliding ray attack generator.
package srag_pkg;

   typedef enum logic [1:0] {
      CMD_ORTH_ATTACK = 2'd0,
      CMD_DIAG_ATTACK = 2'd1,
      CMD_ORTH_MASK   = 2'd2,
      CMD_DIAG_MASK   = 2'd3
   } command_type;

   typedef logic signed [4:0] coord_type;
   typedef logic [63:0]       board_type;

   localparam int        NUM_DIRS  = 4;
   localparam int        MAX_STEPS = 7;

   localparam coord_type ATTACK_LO = 5'sd0;
   localparam coord_type ATTACK_HI = 5'sd7;
   localparam coord_type MASK_LO   = 5'sd1;
   localparam coord_type MASK_HI   = 5'sd6;

   localparam coord_type ORTH_DR [NUM_DIRS] = '{5'sd1, -5'sd1, 5'sd0, 5'sd0};
   localparam coord_type ORTH_DC [NUM_DIRS] = '{5'sd0, 5'sd0, 5'sd1, -5'sd1};
   localparam coord_type DIAG_DR [NUM_DIRS] = '{5'sd1, 5'sd1, -5'sd1, -5'sd1};
   localparam coord_type DIAG_DC [NUM_DIRS] = '{5'sd1, -5'sd1, 5'sd1, -5'sd1};

endpackage

// ===== rtl/srag_ray_unit.sv =====
// Combinational ray fill: four rays from the origin, blocker-limited or mask-limited.
module srag_ray_unit (
   input  srag_pkg::command_type command,
   input  logic [5:0]            square,
   input  srag_pkg::board_type   occupancy,
   output srag_pkg::board_type   attack_set
);
   import srag_pkg::*;

   always_comb begin
      board_type acc;
      coord_type lo;
      coord_type hi;
      coord_type dr;
      coord_type dc;
      coord_type row_v;
      coord_type col_v;
      logic      use_occ;
      logic      diag;
      logic      alive;
      logic      in_row;
      logic      in_col;
      logic [5:0] idx;

      acc     = '0;
      diag    = (command == CMD_DIAG_ATTACK) || (command == CMD_DIAG_MASK);
      use_occ = (command == CMD_ORTH_ATTACK) || (command == CMD_DIAG_ATTACK);
      lo      = use_occ ? ATTACK_LO : MASK_LO;
      hi      = use_occ ? ATTACK_HI : MASK_HI;
      for (int d = 0; d < NUM_DIRS; d++) begin
         dr    = diag ? DIAG_DR[d] : ORTH_DR[d];
         dc    = diag ? DIAG_DC[d] : ORTH_DC[d];
         row_v = coord_type'({2'b00, square[5:3]});
         col_v = coord_type'({2'b00, square[2:0]});
         alive = 1'b1;
         for (int k = 0; k < MAX_STEPS; k++) begin
            row_v  = row_v + dr;
            col_v  = col_v + dc;
            in_row = (dr == 5'sd0) || ((row_v >= lo) && (row_v <= hi));
            in_col = (dc == 5'sd0) || ((col_v >= lo) && (col_v <= hi));
            idx    = {row_v[2:0], col_v[2:0]};
            if (alive && in_row && in_col) begin
               acc[idx] = 1'b1;
               if (use_occ && occupancy[idx]) begin
                  alive = 1'b0;
               end
            end else begin
               alive = 1'b0;
            end
         end
      end
      attack_set = acc;
   end

endmodule

// ===== rtl/sliding_ray_attack_generator_top.sv =====
// Top level of the sliding ray attack generator: request register, ray fill, result register.
//
// Usage:
//   Request channel (req_*): tuser carries the command (orthogonal or diagonal
//   attacks, orthogonal or diagonal blocker mask); tdata carries the origin
//   square and the 64-bit occupancy. One result per request on rsp_*, whose
//   tdata is the 64-bit square set.
//   Path: the request is held in an input register, the four rays are filled by
//   combinational logic (at most seven steps per ray), and the set lands in the
//   result register.
//   Throughput: one request per cycle while rsp_tready stays high.
//   Stall: when rsp_tready is low the result register holds its set, the input
//   register keeps its request, and req_tready drops once both are full; no
//   request is lost or repeated. A new request is taken while the result still
//   waits as long as the input register is free.
//   Reset: both valid flags clear; no state beyond the pipeline exists.
module sliding_ray_attack_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   input  logic [71:0] req_tdata,   // [5:0] square, [69:6] occupancy, [71:70] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [63:0] attack_set
);
   import srag_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   command_type in_command_ff;
   logic [5:0]  in_square_ff;
   board_type   in_occ_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   board_type   out_set_ff;
   board_type   fill_set;
   logic        advance;
   logic        take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   srag_ray_unit u_rays (
      .command    (in_command_ff),
      .square     (in_square_ff),
      .occupancy  (in_occ_ff),
      .attack_set (fill_set)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_command_ff <= command_type'(req_tuser);
         in_square_ff  <= req_tdata[5:0];
         in_occ_ff     <= req_tdata[69:6];
      end
      if (advance) begin
         out_set_ff <= fill_set;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_set_ff;

endmodule

// ===== sim/sliding_ray_attack_generator_top_test.sv =====
// Testbench for the sliding ray attack generator: directed edge cases and randomised traffic.
module sliding_ray_attack_generator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import srag_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = CMD_ORTH_ATTACK;   // [1:0] command
   logic [71:0] req_tdata = '0;                // [5:0] square, [69:6] occupancy, [71:70] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [63:0] rsp_tdata;                     // [63:0] attack_set

   int        sender_idle_pct = 0;
   int        receiver_stall_pct = 0;
   int        mismatch_count = 0;
   int        quiet_cycles = 0;
   board_type expected_attack_sets[$];

   sliding_ray_attack_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic board_type predict_attack_set(command_type cmd, logic [5:0] square,
                                                    board_type occupancy);
      board_type acc;
      int        row0, col0, row, col, dr, dc, lo, hi;
      bit        diagonal, blocked, use_occupancy;
      acc = '0;
      row0 = square[5:3];
      col0 = square[2:0];
      diagonal = (cmd == CMD_DIAG_ATTACK) || (cmd == CMD_DIAG_MASK);
      use_occupancy = (cmd == CMD_ORTH_ATTACK) || (cmd == CMD_DIAG_ATTACK);
      lo = use_occupancy ? 0 : 1;
      hi = use_occupancy ? 7 : 6;
      for (int k = 0; k < 4; k++) begin
         if (diagonal) begin
            dr = (k < 2) ? 1 : -1;
            dc = (k % 2 == 0) ? 1 : -1;
         end else begin
            dr = (k == 0) ? 1 : (k == 1) ? -1 : 0;
            dc = (k == 2) ? 1 : (k == 3) ? -1 : 0;
         end
         row = row0 + dr;
         col = col0 + dc;
         blocked = 1'b0;
         while (!blocked && (dr == 0 || (row >= lo && row <= hi))
                && (dc == 0 || (col >= lo && col <= hi))) begin
            acc[row * 8 + col] = 1'b1;
            if (use_occupancy && occupancy[row * 8 + col])
               blocked = 1'b1;
            row += dr;
            col += dc;
         end
      end
      return acc;
   endfunction

   // predict on each accepted request, compare each accepted response
   always @(posedge clock) begin
      board_type expected;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_attack_sets.push_back(predict_attack_set(command_type'(req_tuser),
                                                              req_tdata[5:0],
                                                              req_tdata[69:6]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_attack_sets.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: attack_set %016h", rsp_tdata);
            end else begin
               expected = expected_attack_sets.pop_front();
               if (rsp_tdata !== expected) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("attack_set mismatch: expected %016h, got %016h",
                              expected, rsp_tdata);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("** sliding_ray_attack_generator_top: FAILED **");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   task automatic send_request(command_type cmd, logic [5:0] square, board_type occupancy);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, occupancy, square};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic test_edge_cases();
      command_type cmd;
      for (int c = 0; c < 4; c++) begin
         cmd = command_type'(c);
         send_request(cmd, 6'd0, 64'h0);
         send_request(cmd, 6'd63, {64{1'b1}});
         send_request(cmd, 6'd27, 64'h1 << 27);
         send_request(cmd, 6'd7, 64'h0);
         send_request(cmd, 6'd56, {64{1'b1}} ^ (64'h1 << 56));
      end
      send_request(CMD_ORTH_MASK, 6'd8, {64{1'b1}});
      send_request(CMD_DIAG_ATTACK, 6'd54, 64'h0);
      send_request(CMD_ORTH_ATTACK, 6'd9, 64'h0042_0000_0000_0200);
      send_request(CMD_DIAG_MASK, 6'd36, 64'h0);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
      board_type   occupancy;
      logic [5:0]  square;
      command_type cmd;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         cmd = command_type'($urandom_range(0, 3));
         square = 6'($urandom_range(0, 63));
         case ($urandom_range(0, 3))
            0: occupancy = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            1: occupancy = {$urandom, $urandom} | {$urandom, $urandom};
            2: occupancy = {$urandom, $urandom};
            default: occupancy = (64'h1 << $urandom_range(0, 63))
                                 | (64'h1 << $urandom_range(0, 63));
         endcase
         if ($urandom_range(0, 3) == 0)
            occupancy[square] = 1'b1;
         send_request(cmd, square, occupancy);
      end
   endtask

   initial begin
      int drain_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_random_traffic(0, 0, 275);
      test_random_traffic(54, 0, 275);
      test_random_traffic(0, 54, 275);
      test_random_traffic(35, 35, 275);
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (expected_attack_sets.size() != 0 && drain_cycles < STALL_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      if (expected_attack_sets.size() != 0) begin
         mismatch_count++;
         $display("%0d responses never arrived", expected_attack_sets.size());
      end
      if (mismatch_count == 0) begin
         $display("** sliding_ray_attack_generator_top: PASSED **");
      end else begin
         $display("** sliding_ray_attack_generator_top: FAILED **");
      end
      $finish;
   end

endmodule
